@@ hw/rtl/slab_object_allocator_assert.svh @@
// assertion macros for the slab allocator checker
`ifndef SLAB_OBJECT_ALLOCATOR_ASSERT_SVH
`define SLAB_OBJECT_ALLOCATOR_ASSERT_SVH

// property that must hold at every edge out of reset
`define SOA_ASSERT(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// implication checked in the cycle after the antecedent
`define SOA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/soa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soa_pkg
// shared constants, types and codes of the slab object allocator
// ----------------------------------------------------------------------------
package soa_pkg;
	localparam int PageBytes = 4096;
	localparam int MaxSlabs = 16;
	localparam int MaxObjs = 512;
	localparam int HeaderBytes = 64;
	localparam int WordsPerSlab = (MaxObjs + 63) / 64;
	localparam int SlabW = $clog2(MaxSlabs);
	localparam int LinkW = 5;
	localparam int WordW = $clog2(WordsPerSlab);
	localparam int MemW = $clog2(MaxSlabs * WordsPerSlab);
	localparam int IdxW = $clog2(MaxObjs);
	localparam int CntW = IdxW + 1;
	localparam int AddrW = 48;
	localparam int UseW = 14;
	localparam logic [LinkW-1:0] LinkNull = 5'd31;

	localparam logic [1:0] StOk = 2'd0;
	localparam logic [1:0] StExhausted = 2'd1;
	localparam logic [1:0] StBadFree = 2'd2;

	localparam logic [1:0] CfgObjBytes = 2'd0;
	localparam logic [1:0] CfgAlign = 2'd1;
	localparam logic [1:0] CfgBase = 2'd2;

	localparam logic ReqAlloc = 1'b0;
	localparam logic ReqFree = 1'b1;

	typedef enum logic [4:0] {
		S_IDLE, S_CLR, S_GEO, S_DISPATCH,
		S_A_OPEN, S_A_SCAN, S_A_SET, S_A_ADDR, S_A_MUL,
		S_F_OFF, S_F_SDIV, S_F_IDIV, S_F_CHK, S_F_RD, S_F_CLR, S_F_LINK,
		S_OUT
	} state_t;

	typedef struct packed {
		logic clr_step;
		logic geo;
		logic a_open;
		logic a_scan;
		logic a_set;
		logic a_addr;
		logic mul_step;
		logic f_off;
		logic div_start;
		logic div_step;
		logic f_idiv;
		logic f_rd;
		logic f_clr;
		logic f_link;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic nodes_done;
		logic mul_done;
		logic scan_done;
		logic div_done;
		logic exhausted;
		logic free_bad;
	} sts_t;
endpackage

@@ hw/rtl/soa_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soa_req_if / soa_rsp_if
// request and response channels of the slab allocator
// ----------------------------------------------------------------------------
interface soa_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [47:0] free_addr;
	modport source (output valid, req_type, free_addr, input ready);
	modport sink (input valid, req_type, free_addr, output ready);
endinterface

interface soa_rsp_if;
	logic        valid;
	logic        ready;
	logic [47:0] obj_addr;
	logic [1:0]  status;
	logic [13:0] objects_in_use;
	modport source (output valid, obj_addr, status, objects_in_use, input ready);
	modport sink (input valid, obj_addr, status, objects_in_use, output ready);
endinterface

@@ hw/rtl/soa_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soa_ctrl
// sequencer for allocate and free requests
// ----------------------------------------------------------------------------
module soa_ctrl import soa_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   cfg_we,
	input  logic   req_valid,
	input  logic   req_type,
	output logic   req_ready,
	input  logic   out_free,
	input  sts_t   sts,
	output cmd_t   cmd
);
	state_t state_q, state_d;
	logic   type_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			type_q <= ReqAlloc;
		end else begin
			state_q <= state_d;
			if (req_valid && req_ready) type_q <= req_type;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		req_ready = 1'b0;
		if (cfg_we) begin
			state_d = S_CLR;
		end else begin
			unique case (state_q)
				S_CLR: begin
					cmd.clr_step = 1'b1;
					if (sts.clr_done) state_d = S_GEO;
				end
				S_GEO: begin
					cmd.geo = 1'b1;
					if (sts.nodes_done) state_d = S_IDLE;
				end
				S_IDLE: begin
					req_ready = out_free;
					if (req_valid && out_free) state_d = S_DISPATCH;
				end
				S_DISPATCH: state_d = (type_q == ReqAlloc) ? S_A_OPEN : S_F_OFF;
				S_A_OPEN: begin
					cmd.a_open = 1'b1;
					state_d = sts.exhausted ? S_OUT : S_A_SCAN;
				end
				S_A_SCAN: begin
					cmd.a_scan = 1'b1;
					if (sts.scan_done) state_d = S_A_SET;
				end
				S_A_SET: begin
					cmd.a_set = 1'b1;
					state_d = S_A_MUL;
				end
				S_A_MUL: begin
					cmd.mul_step = 1'b1;
					if (sts.mul_done) state_d = S_A_ADDR;
				end
				S_A_ADDR: begin
					cmd.a_addr = 1'b1;
					state_d = S_OUT;
				end
				S_F_OFF: begin
					cmd.f_off = 1'b1;
					cmd.div_start = 1'b1;
					state_d = S_F_SDIV;
				end
				S_F_SDIV: begin
					cmd.div_step = 1'b1;
					if (sts.div_done) state_d = S_F_IDIV;
				end
				S_F_IDIV: begin
					cmd.f_idiv = 1'b1;
					cmd.div_start = 1'b1;
					state_d = S_F_CHK;
				end
				S_F_CHK: begin
					cmd.div_step = 1'b1;
					if (sts.div_done) state_d = S_F_RD;
				end
				S_F_RD: begin
					cmd.f_rd = 1'b1;
					state_d = S_F_CLR;
				end
				S_F_CLR: begin
					cmd.f_clr = 1'b1;
					state_d = sts.free_bad ? S_OUT : S_F_LINK;
				end
				S_F_LINK: begin
					cmd.f_link = 1'b1;
					state_d = S_OUT;
				end
				S_OUT: begin
					cmd.load_out = 1'b1;
					state_d = S_IDLE;
				end
				default: state_d = S_CLR;
			endcase
		end
	end
endmodule

@@ hw/rtl/soa_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soa_dp
// geometry, bitmap memory, slab lists, shared divider and address math
// ----------------------------------------------------------------------------
module soa_dp import soa_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [47:0]      cfg_data,
	input  logic             req_fire,
	input  logic [AddrW-1:0] req_addr,
	input  cmd_t             cmd,
	output sts_t             sts,
	output logic [AddrW-1:0] res_addr,
	output logic [1:0]       res_status,
	output logic [UseW-1:0]  res_used
);
	logic [16:0]      obj_bytes_q;
	logic [3:0]       align_q;
	logic [AddrW-1:0] base_q;

	// geometry
	logic [17:0] obj_q;
	logic [16:0] doff_q;
	logic [16:0] slab_bytes_q;
	logic [4:0]  slab_log_q;
	logic [CntW-1:0] nodes_q;

	// bitmap memory, registered read
	logic [63:0] bmp_mem [MaxSlabs*WordsPerSlab];
	logic [63:0] rd_q;
	logic [MemW-1:0] clr_ptr_q;

	logic [CntW-1:0]  fcnt_q [MaxSlabs];
	logic [LinkW-1:0] next_q [MaxSlabs];
	logic [LinkW-1:0] prev_q [MaxSlabs];
	logic [LinkW-1:0] phead_q, fhead_q;
	logic [SlabW:0]   opened_q;
	logic [UseW-1:0]  used_q;

	logic [SlabW-1:0] cur_s_q;
	logic [IdxW-1:0]  idx_q;
	logic [WordW:0]   word_q;
	logic             rd_pend_q;
	logic             found_q;
	logic [1:0]       stat_q;
	logic [AddrW-1:0] off_q;

	// shared restoring divider: 48-bit dividend, 18-bit divisor, 2 bits a step
	logic [AddrW-1:0] dq_q;
	logic [18:0]      drem_q;
	logic [17:0]      dden_q;
	logic [5:0]       dcnt_q;

	// shift-add multiplier idx * obj, 2 bits a step
	logic [AddrW-1:0] mac_q;
	logic [IdxW:0]    mbits_q;
	logic [17:0]      mcand_q;
	logic [3:0]       mcnt_q;

	// geometry math
	logic [17:0] align_m;
	logic [17:0] sz;
	logic [17:0] obj_c;
	logic [16:0] doff_c;
	logic [12:0] rest_c;
	logic [24:0] o64;
	logic [4:0]  slog_c;
	logic [16:0] total_c;
	logic [16:0] avail_c;

	always_comb begin
		align_m = (18'd1 << align_q) - 18'd1;
		sz = (obj_bytes_q == '0) ? 18'd1 : {1'b0, obj_bytes_q};
		obj_c = (sz + align_m) & ~align_m;
		doff_c = 17'((18'(HeaderBytes) + align_m) & ~align_m);
		rest_c = (doff_c < 17'(PageBytes)) ? 13'(17'(PageBytes) - doff_c) : '0;
		o64 = {7'd0, obj_c};
		if ((o64 << 6) <= 25'(rest_c)) slog_c = 5'd12;
		else if ((o64 << 4) <= 25'(rest_c)) slog_c = 5'd13;
		else if ((o64 << 2) <= 25'(rest_c)) slog_c = 5'd14;
		else if (o64 <= 25'(rest_c)) slog_c = 5'd15;
		else slog_c = 5'd16;
		total_c = 17'(18'd1 << slog_c);
		avail_c = (total_c > doff_c) ? total_c - doff_c : '0;
	end

	// scan of the fetched word
	logic [5:0] lz_bit;
	logic       lz_any;
	always_comb begin
		lz_bit = '0;
		lz_any = 1'b0;
		for (int b = 63; b >= 0; b--) begin
			if (!rd_q[b]) begin
				lz_bit = 6'(b);
				lz_any = 1'b1;
			end
		end
	end

	logic [IdxW-1:0] cand_idx;
	assign cand_idx = IdxW'({word_q[WordW-1:0], lz_bit});

	logic [MemW-1:0] cur_word_addr;
	assign cur_word_addr = {cur_s_q, idx_q[IdxW-1:6]};

	logic [SlabW-1:0] ph_s;
	assign ph_s = phead_q[SlabW-1:0];

	// node count grows one object per cycle until the slab is filled or MaxObjs is reached
	logic [16:0] nrem_q;
	logic        nodes_grow;
	assign nodes_grow = ({1'b0, nrem_q} + obj_c <= 18'(avail_c)) &&
		(nodes_q < CntW'(MaxObjs));

	assign sts.clr_done = (clr_ptr_q == MemW'(MaxSlabs*WordsPerSlab-1));
	assign sts.nodes_done = !nodes_grow;
	assign sts.mul_done = (mcnt_q == '0);
	assign sts.div_done = (dcnt_q == '0);
	assign sts.exhausted = (phead_q == LinkNull) &&
		((opened_q >= (SlabW+1)'(MaxSlabs)) || (nodes_q == '0));
	assign sts.scan_done = !rd_pend_q && (found_q ||
		(word_q == (WordW+1)'(WordsPerSlab)));
	assign sts.free_bad = (stat_q != StOk) || !rd_q[idx_q[5:0]];

	logic [18:0] dtry;
	logic [18:0] dtry2;
	logic [18:0] drem1;
	logic        dbit1, dbit2;
	always_comb begin
		dtry = {drem_q[17:0], dq_q[AddrW-1]};
		dbit1 = (dtry >= {1'b0, dden_q});
		drem1 = dbit1 ? dtry - {1'b0, dden_q} : dtry;
		dtry2 = {drem1[17:0], dq_q[AddrW-2]};
		dbit2 = (dtry2 >= {1'b0, dden_q});
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_step) bmp_mem[clr_ptr_q] <= '0;
		else if (cmd.a_set) bmp_mem[cur_word_addr] <= rd_q | (64'd1 << idx_q[5:0]);
		else if (cmd.f_clr && stat_q == StOk)
			bmp_mem[cur_word_addr] <= rd_q & ~(64'd1 << idx_q[5:0]);
		if (cmd.f_rd) rd_q <= bmp_mem[{cur_s_q, dq_q[IdxW-1:6]}];
		else if (cmd.a_scan && !found_q) rd_q <= bmp_mem[{cur_s_q, word_q[WordW-1:0]}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obj_bytes_q <= 17'd64;
			align_q <= 4'd3;
			base_q <= '0;
			clr_ptr_q <= '0;
			phead_q <= LinkNull;
			fhead_q <= LinkNull;
			opened_q <= '0;
			used_q <= '0;
			word_q <= '0;
			rd_pend_q <= 1'b0;
			found_q <= 1'b0;
			stat_q <= StOk;
			dcnt_q <= '0;
			mcnt_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CfgObjBytes: obj_bytes_q <= cfg_data[16:0];
					CfgAlign:    align_q <= cfg_data[3:0];
					CfgBase:     base_q <= cfg_data;
					default: ;
				endcase
				clr_ptr_q <= '0;
				phead_q <= LinkNull;
				fhead_q <= LinkNull;
				opened_q <= '0;
				used_q <= '0;
			end
			if (cmd.clr_step) clr_ptr_q <= clr_ptr_q + MemW'(1);
			if (req_fire) begin
				stat_q <= StOk;
				off_q <= req_addr;
				found_q <= 1'b0;
			end
			if (cmd.a_open) begin
				word_q <= '0;
				rd_pend_q <= 1'b1;
				found_q <= 1'b0;
				if (sts.exhausted) begin
					stat_q <= StExhausted;
				end else if (phead_q == LinkNull) begin
					cur_s_q <= opened_q[SlabW-1:0];
					fcnt_q[opened_q[SlabW-1:0]] <= nodes_q;
					next_q[opened_q[SlabW-1:0]] <= LinkNull;
					prev_q[opened_q[SlabW-1:0]] <= LinkNull;
					phead_q <= LinkW'(opened_q);
					opened_q <= opened_q + (SlabW+1)'(1);
				end else begin
					cur_s_q <= ph_s;
				end
			end
			if (cmd.a_scan) begin
				if (rd_pend_q) begin
					rd_pend_q <= 1'b0;
				end else if (!found_q) begin
					if (lz_any && {1'b0, cand_idx} < nodes_q) begin
						found_q <= 1'b1;
						idx_q <= cand_idx;
					end else begin
						word_q <= word_q + (WordW+1)'(1);
						rd_pend_q <= 1'b1;
					end
				end
			end
			if (cmd.a_set) begin
				// free count is never zero for a partial slab, so bitmap has a hole
				used_q <= used_q + UseW'(1);
				fcnt_q[cur_s_q] <= fcnt_q[cur_s_q] - CntW'(1);
				if (fcnt_q[cur_s_q] == CntW'(1)) begin
					phead_q <= next_q[cur_s_q];
					if (next_q[cur_s_q] != LinkNull)
						prev_q[next_q[cur_s_q][SlabW-1:0]] <= LinkNull;
					next_q[cur_s_q] <= fhead_q;
					prev_q[cur_s_q] <= LinkNull;
					if (fhead_q != LinkNull) prev_q[fhead_q[SlabW-1:0]] <= LinkW'(cur_s_q);
					fhead_q <= LinkW'(cur_s_q);
				end
				mac_q <= '0;
				mbits_q <= {1'b0, idx_q};
				mcand_q <= obj_q;
				mcnt_q <= 4'((IdxW + 1) / 2);
			end
			if (cmd.mul_step && mcnt_q != '0) begin
				mac_q <= (mac_q << 2) + AddrW'(mcand_q * mbits_q[IdxW -: 2]);
				mbits_q <= mbits_q << 2;
				mcnt_q <= mcnt_q - 4'd1;
			end
			if (cmd.a_addr) begin
				off_q <= base_q + (AddrW'(cur_s_q) << slab_log_q) + AddrW'(doff_q) + mac_q;
			end
			if (cmd.f_off) begin
				off_q <= off_q - base_q;
			end
			if (cmd.div_start) begin
				dq_q <= cmd.f_off ? off_q - base_q
					: AddrW'((off_q[16:0] & (slab_bytes_q - 17'd1)) - doff_q);
				dden_q <= cmd.f_off ? {1'b0, slab_bytes_q} : obj_q;
				drem_q <= '0;
				dcnt_q <= 6'(AddrW / 2);
			end
			if (cmd.div_step && dcnt_q != '0) begin
				dq_q <= {dq_q[AddrW-3:0], dbit1, dbit2};
				drem_q <= dbit2 ? dtry2 - {1'b0, dden_q} : dtry2;
				dcnt_q <= dcnt_q - 6'd1;
			end
			if (cmd.f_idiv) begin
				// slot quotient ready; offset kept in off_q
				if (dq_q >= AddrW'(opened_q) ||
					(off_q[16:0] & (slab_bytes_q - 17'd1)) < doff_q)
					stat_q <= StBadFree;
				cur_s_q <= dq_q[SlabW-1:0];
			end
			if (cmd.f_rd) begin
				if (stat_q == StOk && dq_q >= AddrW'(nodes_q)) stat_q <= StBadFree;
				idx_q <= dq_q[IdxW-1:0];
			end
			if (cmd.f_clr) begin
				if (stat_q == StOk && !rd_q[idx_q[5:0]]) stat_q <= StBadFree;
			end
			if (cmd.f_link) begin
				fcnt_q[cur_s_q] <= fcnt_q[cur_s_q] + CntW'(1);
				used_q <= used_q - UseW'(1);
				if (fcnt_q[cur_s_q] == '0) begin
					if (next_q[cur_s_q] != LinkNull)
						prev_q[next_q[cur_s_q][SlabW-1:0]] <= prev_q[cur_s_q];
					if (prev_q[cur_s_q] != LinkNull)
						next_q[prev_q[cur_s_q][SlabW-1:0]] <= next_q[cur_s_q];
					prev_q[cur_s_q] <= LinkNull;
					next_q[cur_s_q] <= phead_q;
					if (phead_q != LinkNull) prev_q[ph_s] <= LinkW'(cur_s_q);
					phead_q <= LinkW'(cur_s_q);
					if (prev_q[cur_s_q] == LinkNull) begin
						fhead_q <= next_q[cur_s_q];
						// the old full head points back at nothing; fix if relinked slab was head
						if (phead_q != LinkNull && next_q[cur_s_q] == phead_q)
							prev_q[ph_s] <= LinkW'(cur_s_q);
					end
				end
			end
		end
	end

	// f_rd needs a fresh bitmap word; idx is set from the quotient there, so
	// the read address for that cycle comes from dq
	always_ff @(posedge clk) begin
		if (cmd.geo) begin
			obj_q <= obj_c;
			doff_q <= doff_c;
			slab_log_q <= slog_c;
			slab_bytes_q <= total_c;
		end
		if (cmd.load_out) begin
			res_status <= stat_q;
			res_addr <= (stat_q == StOk && cmd.load_out && found_q) ? off_q : '0;
			res_used <= used_q;
		end
	end

	// node count: avail / obj as a small loop that runs beside the clear pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nodes_q <= '0;
			nrem_q <= '0;
		end else if (cfg_we) begin
			nrem_q <= '0;
			nodes_q <= '0;
		end else if (nodes_grow) begin
			nrem_q <= 17'({1'b0, nrem_q} + obj_c);
			nodes_q <= nodes_q + CntW'(1);
		end
	end
endmodule

@@ hw/rtl/slab_object_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slab_object_allocator
// fixed-size object allocator over a bounded pool of bitmap slabs
// ----------------------------------------------------------------------------
// usage:
// req carries one beat per request: req_type 0 allocates, 1 frees free_addr.
// rsp returns exactly one beat per request with obj_addr, status and
// objects_in_use after the request.
// an allocate runs a bitmap word scan (up to 8 words) and a 2-bit-a-step
// multiplier before rsp valid; an exhausted pool answers without either.
// a free runs two passes of the shared 2-bit-a-step divider (slab number,
// then object index).
// one request is in flight at a time; the next is taken once the result
// register is empty.
// after reset and after any configuration write to a used index the block
// clears all 128 bitmap memory words while it counts objects per slab, one a
// cycle up to 512, and accepts no request until both are done.
// a stalled rsp holds its beat; no new request is taken until it drains.
// ----------------------------------------------------------------------------
module slab_object_allocator import soa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [47:0] cfg_data,
	soa_req_if.sink     req,
	soa_rsp_if.source   rsp
);
	cmd_t cmd;
	sts_t sts;
	logic rsp_valid_q;
	logic ready;
	logic cfg_hit;
	logic [AddrW-1:0] r_addr;
	logic [1:0] r_status;
	logic [UseW-1:0] r_used;

	assign req.ready = ready;

	// writes to an unused index leave everything alone
	assign cfg_hit = cfg_we && (cfg_index <= CfgBase);

	soa_ctrl u_ctrl (
		.clk, .arst_n, .cfg_we(cfg_hit),
		.req_valid(req.valid), .req_type(req.req_type), .req_ready(ready),
		.out_free(!rsp_valid_q), .sts, .cmd
	);

	soa_dp u_dp (
		.clk, .arst_n, .cfg_we(cfg_hit), .cfg_index, .cfg_data,
		.req_fire(req.valid && ready), .req_addr(req.free_addr),
		.cmd, .sts, .res_addr(r_addr), .res_status(r_status), .res_used(r_used)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rsp_valid_q <= 1'b0;
		else if (cmd.load_out) rsp_valid_q <= 1'b1;
		else if (rsp.ready) rsp_valid_q <= 1'b0;
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.obj_addr = r_addr;
	assign rsp.status = r_status;
	assign rsp.objects_in_use = r_used;
endmodule

@@ hw/rtl/soa_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soa_checker
// port-level checks of the slab allocator
// ----------------------------------------------------------------------------
`include "slab_object_allocator_assert.svh"
module soa_checker import soa_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [47:0] obj_addr,
	input logic [1:0]  status
);
	`SOA_ASSERT(a_status_range, !rsp_valid || status <= StBadFree, "status code out of range")
	`SOA_ASSERT(a_err_zero, !rsp_valid || status == StOk || obj_addr == '0, "error with address")
	`SOA_ASSERT(a_one_busy, !(req_ready && rsp_valid), "request taken while result pending")
	`SOA_ASSERT_NEXT(a_no_back, req_valid && req_ready, !rsp_valid, "result in next cycle")
endmodule

bind slab_object_allocator soa_checker u_chk (
	.clk, .arst_n,
	.req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
	.obj_addr(rsp.obj_addr), .status(rsp.status)
);

@@ sim/soa_alloc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soa_alloc_checker
// watches the request, response and configuration ports of the slab
// allocator, predicts every response from its own copy of the slab lists
// and bitmaps, and compares the responses field by field in order
// ----------------------------------------------------------------------------
module soa_alloc_checker import soa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [47:0] cfg_data,
	soa_req_if          req,
	soa_rsp_if          rsp,
	output int          errors,
	output int          pending
);
	typedef struct {
		logic [47:0] obj_addr;
		logic [1:0]  status;
		logic [13:0] objects_in_use;
	} alloc_rsp_t;

	localparam longint unsigned AddrMask = 64'hFFFF_FFFF_FFFF;

	alloc_rsp_t expected_rsps[$];

	logic [16:0]  reg_obj_bytes;
	logic [3:0]   reg_align_log2;
	logic [47:0]  reg_pool_base;

	logic [511:0] bitmap [MaxSlabs];
	int           free_cnt [MaxSlabs];
	int           nxt [MaxSlabs];
	int           prv [MaxSlabs];
	int           partial_head, full_head, slabs_open, in_use;
	longint unsigned obj_sz, data_off, slab_sz, slots;

	function automatic void clear_slabs();
		for (int s = 0; s < MaxSlabs; s++) begin
			bitmap[s] = '0;
			free_cnt[s] = 0;
			nxt[s] = 0;
			prv[s] = 0;
		end
		partial_head = LinkNull;
		full_head = LinkNull;
		slabs_open = 0;
		in_use = 0;
	endfunction

	function automatic void derive_geometry();
		longint unsigned align, sz, rest, pages;
		align = 64'd1 << reg_align_log2;
		sz = (reg_obj_bytes == 0) ? 1 : reg_obj_bytes;
		obj_sz = (sz + align - 1) & ~(align - 1);
		data_off = (HeaderBytes + align - 1) & ~(align - 1);
		rest = (data_off < PageBytes) ? PageBytes - data_off : 0;
		if (obj_sz * 64 <= rest) pages = 1;
		else if (obj_sz * 16 <= rest) pages = 2;
		else if (obj_sz * 4 <= rest) pages = 4;
		else if (obj_sz <= rest) pages = 8;
		else pages = 16;
		slab_sz = pages * PageBytes;
		slots = (slab_sz > data_off) ? (slab_sz - data_off) / obj_sz : 0;
		if (slots > MaxObjs) slots = MaxObjs;
	endfunction

	function automatic logic [1:0] take_object(output logic [47:0] addr);
		int s, i;
		addr = '0;
		if (partial_head == LinkNull) begin
			if (slabs_open >= MaxSlabs || slots == 0) return StExhausted;
			s = slabs_open;
			slabs_open++;
			bitmap[s] = '0;
			free_cnt[s] = slots;
			nxt[s] = LinkNull;
			prv[s] = LinkNull;
			partial_head = s;
		end
		s = partial_head;
		for (i = 0; i < slots; i++)
			if (!bitmap[s][i]) break;
		if (i >= slots) return StExhausted;
		bitmap[s][i] = 1'b1;
		free_cnt[s]--;
		in_use++;
		if (free_cnt[s] == 0) begin
			// slab filled up: move it from the partial list to the full list
			partial_head = nxt[s];
			if (partial_head < MaxSlabs) prv[partial_head] = LinkNull;
			nxt[s] = full_head;
			prv[s] = LinkNull;
			if (full_head < MaxSlabs) prv[full_head] = s;
			full_head = s;
		end
		addr = (reg_pool_base + longint'(s) * slab_sz + data_off + longint'(i) * obj_sz)
			& AddrMask;
		return StOk;
	endfunction

	function automatic logic [1:0] return_object(logic [47:0] fa);
		longint unsigned off, slot, in_slab, idx;
		int s, p, n;
		off = (longint'(fa) - longint'(reg_pool_base)) & AddrMask;
		slot = off / slab_sz;
		in_slab = off % slab_sz;
		if (slot >= slabs_open || in_slab < data_off) return StBadFree;
		idx = (in_slab - data_off) / obj_sz;
		s = slot;
		if (idx >= slots) return StBadFree;
		if (!bitmap[s][idx]) return StBadFree;
		bitmap[s][idx] = 1'b0;
		free_cnt[s]++;
		in_use--;
		if (free_cnt[s] == 1) begin
			p = prv[s];
			n = nxt[s];
			if (n < MaxSlabs) prv[n] = p;
			if (p < MaxSlabs) nxt[p] = n;
			else full_head = n;
			prv[s] = LinkNull;
			nxt[s] = partial_head;
			if (partial_head < MaxSlabs) prv[partial_head] = s;
			partial_head = s;
		end
		return StOk;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		alloc_rsp_t e, got;
		logic [47:0] a;
		logic [1:0] st;
		int nerr;
		nerr = 0;
		if (!arst_n) begin
			reg_obj_bytes = 17'd64;
			reg_align_log2 = 4'd3;
			reg_pool_base = '0;
			clear_slabs();
			derive_geometry();
			expected_rsps.delete();
			errors <= 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CfgObjBytes: reg_obj_bytes = cfg_data[16:0];
					CfgAlign: reg_align_log2 = cfg_data[3:0];
					CfgBase: reg_pool_base = cfg_data;
					default: ;
				endcase
				if (cfg_index <= CfgBase) begin
					clear_slabs();
					derive_geometry();
				end
			end
			// responses belong to older requests, so drain before pushing
			if (rsp.valid && rsp.ready) begin
				got.obj_addr = rsp.obj_addr;
				got.status = rsp.status;
				got.objects_in_use = rsp.objects_in_use;
				if (expected_rsps.size() == 0) begin
					$error("response beat with no request outstanding");
					nerr++;
				end else begin
					e = expected_rsps.pop_front();
					if (got.obj_addr !== e.obj_addr) begin
						$error("obj_addr expected %h got %h", e.obj_addr, got.obj_addr);
						nerr++;
					end
					if (got.status !== e.status) begin
						$error("status expected %0d got %0d", e.status, got.status);
						nerr++;
					end
					if (got.objects_in_use !== e.objects_in_use) begin
						$error("objects_in_use expected %0d got %0d",
							e.objects_in_use, got.objects_in_use);
						nerr++;
					end
				end
			end
			if (req.valid && req.ready) begin
				if (req.req_type == ReqAlloc) st = take_object(a);
				else begin
					st = return_object(req.free_addr);
					a = '0;
				end
				e.obj_addr = (st == StOk) ? a : '0;
				e.status = st;
				e.objects_in_use = in_use[13:0];
				expected_rsps.push_back(e);
			end
			errors <= errors + nerr;
			pending <= expected_rsps.size();
		end
	end
endmodule

@@ sim/tb_slab_object_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_slab_object_allocator
// drives allocate and free requests through several object size, alignment
// and pool base settings; frees mostly hit live objects, with interior,
// header, double and stray addresses mixed in; the checker judges responses
// ----------------------------------------------------------------------------
module tb_slab_object_allocator import soa_pkg::*;;
	localparam int CycleLimit = 1000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = CfgObjBytes;
	logic [47:0] cfg_data = '0;
	int          errors, pending, cycles = 0;
	bit          no_idle = 1'b0;
	logic [47:0] live_objs[$];
	logic [47:0] dead_objs[$];

	soa_req_if req ();
	soa_rsp_if rsp ();

	slab_object_allocator dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .req(req.sink), .rsp(rsp.source)
	);

	soa_alloc_checker checker_i (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .req(req), .rsp(rsp), .errors(errors), .pending(pending)
	);

	always #5 clk = ~clk;

	initial begin
		req.valid = 1'b0;
		req.req_type = ReqAlloc;
		req.free_addr = '0;
		rsp.ready = 1'b0;
	end

	always @(negedge clk)
		rsp.ready <= no_idle || ($urandom_range(99) >= 38);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("FAIL");
			$finish;
		end
	end

	// keep the addresses handed out so frees can target live objects
	always @(posedge clk)
		if (rsp.valid && rsp.ready && rsp.status == StOk && rsp.obj_addr != 0)
			live_objs.push_back(rsp.obj_addr);

	task automatic send_req(logic kind, logic [47:0] addr);
		if (!no_idle && $urandom_range(99) < 38) begin
			req.valid = 1'b0;
			repeat ($urandom_range(3, 1)) @(negedge clk);
		end
		req.req_type = kind;
		req.free_addr = addr;
		req.valid = 1'b1;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		req.valid = 1'b0;
		while (pending != 0 || req.valid) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [47:0] val);
		drain();
		repeat (60) @(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		live_objs.delete();
		dead_objs.delete();
	endtask

	function automatic logic [47:0] rand_addr();
		return {$urandom(), $urandom()};
	endfunction

	task automatic pick_free(output logic [47:0] a);
		int k, r;
		r = $urandom_range(99);
		if (live_objs.size() != 0 && r < 80) begin
			k = $urandom_range(live_objs.size() - 1);
			a = live_objs[k];
			live_objs.delete(k);
			dead_objs.push_back(a);
			// interior address frees the containing object
			if (r >= 65) a = a + $urandom_range(3, 1);
		end else if (dead_objs.size() != 0 && r < 90) begin
			a = dead_objs[$urandom_range(dead_objs.size() - 1)];
		end else begin
			a = rand_addr();
		end
	endtask

	task automatic run_mix(int n, int alloc_pct, bit hold_mid);
		logic [47:0] a;
		for (int i = 0; i < n; i++) begin
			if (hold_mid && i == n / 2) drain();
			if ($urandom_range(99) < alloc_pct || live_objs.size() == 0 &&
					$urandom_range(3) != 0)
				send_req(ReqAlloc, rand_addr());
			else begin
				pick_free(a);
				send_req(ReqFree, a);
			end
		end
	endtask

	initial begin
		logic [47:0] a;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// directed: default geometry, 64 B objects, 127 per two-page slab
		for (int i = 0; i < 6; i++) send_req(ReqAlloc, '0);
		drain();
		a = live_objs[1];
		send_req(ReqFree, a);
		send_req(ReqFree, a);                   // double free
		send_req(ReqFree, live_objs[2] + 5);    // interior address
		send_req(ReqFree, 48'd10);              // header of slab zero
		send_req(ReqFree, 48'd8192 + 48'd100);  // slab never opened
		send_req(ReqFree, 48'd8191);            // last byte of the last object slot
		send_req(ReqFree, '1);                  // top of address space
		send_req(ReqAlloc, '1);                 // reuses the lowest freed slot
		drain();
		live_objs.delete();
		run_mix(180, 60, 1'b0);

		// big objects and a pool at the top of the address space (wraps)
		write_reg(CfgObjBytes, 48'd3000);
		write_reg(CfgAlign, 48'd0);
		write_reg(CfgBase, 48'hFFFF_FFFF_0000);
		run_mix(220, 85, 1'b1);
		run_mix(60, 30, 1'b0);

		// size zero behaves as one byte, 512 objects per slab
		write_reg(CfgObjBytes, 48'd0);
		write_reg(CfgBase, {rand_addr()} & 48'hFFFF_FFFF_0000);
		no_idle = 1'b1;
		run_mix(200, 55, 1'b0);
		no_idle = 1'b0;

		// nothing fits: every allocate reports exhaustion
		write_reg(CfgObjBytes, 48'd65536);
		write_reg(CfgAlign, 48'd12);
		run_mix(60, 70, 1'b0);

		// page alignment: header takes a full page
		write_reg(CfgObjBytes, 48'd1);
		run_mix(220, 70, 1'b0);

		// widest field values
		write_reg(CfgObjBytes, 48'h1FFFF);
		write_reg(CfgAlign, 48'hF);
		write_reg(CfgBase, 48'hFFFF_FFFF_FFFF);
		run_mix(40, 60, 1'b0);

		write_reg(CfgObjBytes, 48'd700);
		write_reg(CfgAlign, 48'd5);
		write_reg(CfgBase, {rand_addr()} & 48'hFFFF_FFFF_0000);
		run_mix(400, 65, 1'b0);

		drain();
		repeat (100) @(posedge clk);
		if (errors == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end
endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/soa_pkg.sv
hw/rtl/soa_if.sv
hw/rtl/soa_ctrl.sv
hw/rtl/soa_dp.sv
hw/rtl/slab_object_allocator.sv
hw/rtl/soa_checker.sv
sim/soa_alloc_checker.sv
sim/tb_slab_object_allocator.sv
